// ===== rtl/psf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_pkg: shared types and constants of the peak finder
// Field widths, window geometry, register indexes and the test status.
// ----------------------------------------------------------------------------
package psf_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int THR_W       = 16;
   localparam int N_THR       = 12;
   localparam int IDX_W       = 20;
   localparam int RATE_OUT_W  = 26;
   localparam int VAR_OUT_W   = 42;
   localparam int WIN_DEPTH   = 13;
   localparam int WIN_IDX_W   = 4;
   localparam int MAX_OUT     = 13;
   localparam int OUT_CNT_W   = 4;
   localparam int DIFF_SHIFT  = 16;
   localparam int CSR_W       = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int REBIN_W     = 11;
   localparam int PHASE_W     = 10;
   localparam int NBR_W       = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REBIN  = 3'd0,
      CSR_PHASE  = 3'd1,
      CSR_BEFORE = 3'd2,
      CSR_AFTER  = 3'd3,
      CSR_THR0   = 3'd4,
      CSR_THR1   = 3'd5,
      CSR_THR2   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic done;
      logic pass;
   } test_status_type;

endpackage

// ===== rtl/psf_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_channels: sample and result channels
// Valid/ready channels carrying one sample beat and one bin result beat.
// ----------------------------------------------------------------------------
interface psf_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [psf_pkg::SAMPLE_W-1:0] rate_sample;
   logic        [psf_pkg::SAMPLE_W-1:0] error_sample;
   logic                                last;

   modport source (output valid, output rate_sample, output error_sample, output last,
                   input ready);
   modport sink (input valid, input rate_sample, input error_sample, input last,
                 output ready);
endinterface

interface psf_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic        [psf_pkg::IDX_W-1:0]      bin_index;
   logic                                  peak_flag;
   logic signed [psf_pkg::RATE_OUT_W-1:0] bin_rate_sum;
   logic        [psf_pkg::VAR_OUT_W-1:0]  bin_variance_sum;
   logic                                  last_res;

   modport source (output valid, output bin_index, output peak_flag, output bin_rate_sum,
                   output bin_variance_sum, output last_res, input ready);
   modport sink (input valid, input bin_index, input peak_flag, input bin_rate_sum,
                 input bin_variance_sum, input last_res, output ready);
endinterface

// ===== rtl/psf_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_cell: one window cell
// Holds one completed bin; takes its neighbor's bin when a new bin enters.
// ----------------------------------------------------------------------------
module psf_cell #(
   parameter int RW = 26,
   parameter int VW = 42
) (
   input  logic                 clock,
   input  logic                 shift_en,
   input  logic signed [RW-1:0] rate_in,
   input  logic        [VW-1:0] var_in,
   output logic signed [RW-1:0] rate_q,
   output logic        [VW-1:0] var_q
);
   logic signed [RW-1:0] rate_ff;
   logic        [VW-1:0] var_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         rate_ff <= rate_in;
         var_ff  <= var_in;
      end
   end

   assign rate_q = rate_ff;
   assign var_q  = var_ff;
endmodule

// ===== rtl/psf_excess.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_excess: neighbor excess test
// Checks diff >= 0 and (diff^2 << 16) >= thr^2 * (var_c + var_n) over four stages;
// with a zero variance sum it checks diff > 0.
module psf_excess #(
   parameter int RW = 26,
   parameter int VW = 42
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [RW-1:0]          rate_c,
   input  logic        [VW-1:0]          var_c,
   input  logic signed [RW-1:0]          rate_n,
   input  logic        [VW-1:0]          var_n,
   input  logic [psf_pkg::THR_W-1:0]     thr,
   output psf_pkg::test_status_type      status
);
   import psf_pkg::*;

   localparam int DW    = RW + 1;
   localparam int SW    = VW + 1;
   localparam int T2W   = 2 * THR_W;
   localparam int LO_W  = SW / 2;
   localparam int HI_W  = SW - LO_W;
   localparam int PLO_W = T2W + LO_W;
   localparam int PHI_W = T2W + HI_W;
   localparam int PW    = T2W + SW;
   localparam int D2W   = 2 * RW;
   localparam int CW    = (D2W + DIFF_SHIFT > PW) ? D2W + DIFF_SHIFT : PW;

   logic [3:0]            stg_ff;
   logic signed [DW-1:0]  diff_ff;
   logic [SW-1:0]         sum_ff;
   logic [T2W-1:0]        thr2_ff;
   logic [D2W-1:0]        d2_ff;
   logic [PLO_W-1:0]      plo_ff;
   logic [PHI_W-1:0]      phi_ff;
   logic [PW-1:0]         prod_ff;
   logic [RW-1:0]         mag;
   logic                  neg;
   logic                  pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff <= '0;
      end else begin
         stg_ff <= {stg_ff[2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         diff_ff <= DW'(rate_c) - DW'(rate_n);
         sum_ff  <= SW'(var_c) + SW'(var_n);
         thr2_ff <= T2W'(thr) * T2W'(thr);
      end
      if (stg_ff[0]) begin
         d2_ff  <= D2W'(mag) * D2W'(mag);
         plo_ff <= PLO_W'(thr2_ff) * PLO_W'(sum_ff[LO_W-1:0]);
      end
      if (stg_ff[1]) begin
         phi_ff <= PHI_W'(thr2_ff) * PHI_W'(sum_ff[SW-1:LO_W]);
      end
      if (stg_ff[2]) begin
         prod_ff <= (PW'(phi_ff) << LO_W) + PW'(plo_ff);
      end
   end

   assign mag = diff_ff[RW-1:0];
   assign neg = diff_ff[DW-1];
   assign pos = !neg && (diff_ff != '0);

   always_comb begin
      status.done = stg_ff[3];
      if (sum_ff == '0) begin
         status.pass = pos;
      end else begin
         status.pass = !neg && ((CW'(d2_ff) << DIFF_SHIFT) >= CW'(prod_ff));
      end
   end
endmodule

// ===== rtl/rebinned_significance_peak_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebinned_significance_peak_finder: rebinned significance peak finder
// One sample beat at a time: each sample passes ST_IDLE and then ST_SCAN; each result
// beat passes ST_SCAN, ST_TEST and ST_OUT, and each neighbor tested (up to 12) goes
// through ST_WAIT and the four-stage excess test shared across all neighbor positions.
// Synchronous active-high reset clears control and series state and sets the configuration registers to defaults.
// ----------------------------------------------------------------------------
module rebinned_significance_peak_finder #(
   parameter int MAX_NEIGHBOURS = 12,
   parameter int MAX_REBIN      = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   psf_req_if.sink                         req_bus,
   psf_rsp_if.source                       rsp_bus,
   input  logic                            csr_write_enable,
   input  logic [psf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [psf_pkg::CSR_W-1:0]       csr_write_data
);
   import psf_pkg::*;

   localparam int CNT_W   = $clog2(MAX_REBIN + 1);
   localparam int LOG_REB = $clog2(MAX_REBIN);
   localparam int RW      = SAMPLE_W + LOG_REB;
   localparam int VW      = 2 * SAMPLE_W + LOG_REB;

   typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_TEST, ST_WAIT, ST_OUT} state_type;

   state_type                 state_ff;
   logic [REBIN_W-1:0]        rebin_ff;
   logic [PHASE_W-1:0]        phase_ff;
   logic [NBR_W-1:0]          cb_ff;
   logic [NBR_W-1:0]          ca_ff;
   logic [N_THR*THR_W-1:0]    thr_ff;
   logic signed [RW-1:0]      rate_acc_ff;
   logic [VW-1:0]             var_acc_ff;
   logic [CNT_W-1:0]          samples_ff;
   logic [PHASE_W-1:0]        skip_ff;
   logic [IDX_W-1:0]          bc_ff;
   logic [IDX_W-1:0]          rn_ff;
   logic                      last_ff;
   logic [OUT_CNT_W-1:0]      cnt_ff;
   logic [NBR_W-1:0]          t_ff;
   logic [WIN_IDX_W-1:0]      d_ff;
   logic                      flag_ff;
   logic signed [RW-1:0]      rc_ff;
   logic [VW-1:0]             vc_ff;
   logic [IDX_W-1:0]          o_idx_ff;
   logic                      o_flag_ff;
   logic signed [RATE_OUT_W-1:0] o_rate_ff;
   logic [VAR_OUT_W-1:0]      o_var_ff;
   logic                      o_last_ff;

   logic [CNT_W-1:0]          reb_cnt;
   logic [CNT_W-1:0]          samples_in;
   logic                      bin_done;
   logic                      in_bin;
   logic signed [RW-1:0]      rate_sum;
   logic [VW-1:0]             var_sum;
   logic [NBR_W:0]            total;
   logic                      valid_win;
   logic [NBR_W-1:0]          after_eff;
   logic [IDX_W-1:0]          bin_dist;
   logic                      due;
   logic                      before_ph;
   logic [NBR_W-1:0]          k;
   logic [WIN_IDX_W:0]        nd;
   logic                      miss;
   logic                      test_end;
   logic                      test_start;
   logic                      shift_en;
   logic [WIN_IDX_W-1:0]      rd_idx;
   logic signed [RW-1:0]      rd_rate;
   logic [VW-1:0]             rd_var;
   logic [THR_W-1:0]          thr_sel;
   test_status_type           test_status;

   logic signed [RW-1:0]      win_rate [WIN_DEPTH];
   logic [VW-1:0]             win_var  [WIN_DEPTH];

   // window: a chain of cells, newest bin in cell 0
   for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_win
      if (i == 0) begin : g_head
         psf_cell #(.RW(RW), .VW(VW)) u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .rate_in  (rate_sum),
            .var_in   (var_sum),
            .rate_q   (win_rate[i]),
            .var_q    (win_var[i])
         );
      end else begin : g_body
         psf_cell #(.RW(RW), .VW(VW)) u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .rate_in  (win_rate[i-1]),
            .var_in   (win_var[i-1]),
            .rate_q   (win_rate[i]),
            .var_q    (win_var[i])
         );
      end
   end

   psf_excess #(.RW(RW), .VW(VW)) u_excess (
      .clock  (clock),
      .reset  (reset),
      .start  (test_start),
      .rate_c (rc_ff),
      .var_c  (vc_ff),
      .rate_n (rd_rate),
      .var_n  (rd_var),
      .thr    (thr_sel),
      .status (test_status)
   );

   always_comb begin
      if (rebin_ff == '0) begin
         reb_cnt = CNT_W'(1);
      end else if (32'(rebin_ff) > MAX_REBIN) begin
         reb_cnt = CNT_W'(MAX_REBIN);
      end else begin
         reb_cnt = CNT_W'(rebin_ff);
      end
   end

   assign samples_in = CNT_W'(samples_ff + 1'b1);
   assign bin_done   = samples_in >= reb_cnt;
   assign in_bin     = skip_ff >= phase_ff;
   assign rate_sum   = rate_acc_ff + RW'(req_bus.rate_sample);
   assign var_sum    = var_acc_ff
                       + VW'((2*SAMPLE_W)'(req_bus.error_sample)
                             * (2*SAMPLE_W)'(req_bus.error_sample));
   assign shift_en   = (state_ff == ST_IDLE) && req_bus.valid && in_bin && bin_done;

   assign total     = (NBR_W+1)'(cb_ff) + (NBR_W+1)'(ca_ff);
   assign valid_win = (total != '0) && (32'(total) <= MAX_NEIGHBOURS);
   assign after_eff = valid_win ? ca_ff : '0;
   assign bin_dist  = IDX_W'(bc_ff - rn_ff - 1'b1);
   assign due       = (cnt_ff < OUT_CNT_W'(MAX_OUT)) && (rn_ff != bc_ff)
                      && (last_ff || (bin_dist >= IDX_W'(after_eff)));

   assign before_ph = t_ff < cb_ff;
   assign k         = before_ph ? NBR_W'(cb_ff - t_ff) : NBR_W'(t_ff - cb_ff + 1'b1);
   assign nd        = before_ph ? (WIN_IDX_W+1)'(d_ff) + (WIN_IDX_W+1)'(k)
                                : (WIN_IDX_W+1)'(d_ff) - (WIN_IDX_W+1)'(k);
   assign miss      = before_ph ? ((rn_ff < IDX_W'(k)) || (nd >= (WIN_IDX_W+1)'(WIN_DEPTH)))
                                : (k > NBR_W'(d_ff));
   assign test_end  = !flag_ff || ((NBR_W+1)'(t_ff) == total);
   assign test_start = (state_ff == ST_TEST) && !test_end && !miss;
   assign thr_sel   = thr_ff[t_ff*THR_W +: THR_W];

   assign rd_idx = (state_ff == ST_SCAN) ? bin_dist[WIN_IDX_W-1:0] : nd[WIN_IDX_W-1:0];

   always_comb begin
      rd_rate = '0;
      rd_var  = '0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         if (rd_idx == WIN_IDX_W'(i)) begin
            rd_rate = win_rate[i];
            rd_var  = win_var[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rebin_ff    <= REBIN_W'(1);
         phase_ff    <= '0;
         cb_ff       <= NBR_W'(1);
         ca_ff       <= NBR_W'(1);
         thr_ff      <= '0;
         rate_acc_ff <= '0;
         var_acc_ff  <= '0;
         samples_ff  <= '0;
         skip_ff     <= '0;
         bc_ff       <= '0;
         rn_ff       <= '0;
         last_ff     <= 1'b0;
         cnt_ff      <= '0;
         t_ff        <= '0;
         d_ff        <= '0;
         flag_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_REBIN:  rebin_ff <= csr_write_data[REBIN_W-1:0];
               CSR_PHASE:  phase_ff <= csr_write_data[PHASE_W-1:0];
               CSR_BEFORE: cb_ff    <= csr_write_data[NBR_W-1:0];
               CSR_AFTER:  ca_ff    <= csr_write_data[NBR_W-1:0];
               CSR_THR0:   thr_ff[0*CSR_W +: CSR_W] <= csr_write_data;
               CSR_THR1:   thr_ff[1*CSR_W +: CSR_W] <= csr_write_data;
               CSR_THR2:   thr_ff[2*CSR_W +: CSR_W] <= csr_write_data;
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid) begin
                  last_ff <= req_bus.last;
                  cnt_ff  <= '0;
                  if (!in_bin) begin
                     skip_ff <= PHASE_W'(skip_ff + 1'b1);
                  end else if (bin_done) begin
                     rate_acc_ff <= '0;
                     var_acc_ff  <= '0;
                     samples_ff  <= '0;
                     bc_ff       <= IDX_W'(bc_ff + 1'b1);
                  end else begin
                     rate_acc_ff <= rate_sum;
                     var_acc_ff  <= var_sum;
                     samples_ff  <= samples_in;
                  end
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (due) begin
                  t_ff <= '0;
                  d_ff <= bin_dist[WIN_IDX_W-1:0];
                  if (bin_dist < IDX_W'(WIN_DEPTH)) begin
                     rc_ff   <= rd_rate;
                     vc_ff   <= rd_var;
                     flag_ff <= valid_win;
                  end else begin
                     rc_ff   <= '0;
                     vc_ff   <= '0;
                     flag_ff <= 1'b0;
                  end
                  state_ff <= ST_TEST;
               end else begin
                  if (last_ff) begin
                     rate_acc_ff <= '0;
                     var_acc_ff  <= '0;
                     samples_ff  <= '0;
                     skip_ff     <= '0;
                     bc_ff       <= '0;
                     rn_ff       <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_TEST: begin
               if (test_end) begin
                  o_idx_ff  <= rn_ff;
                  o_flag_ff <= flag_ff;
                  o_rate_ff <= RATE_OUT_W'(rc_ff);
                  o_var_ff  <= VAR_OUT_W'(vc_ff);
                  o_last_ff <= last_ff && ((cnt_ff == OUT_CNT_W'(MAX_OUT - 1))
                                           || (IDX_W'(rn_ff + 1'b1) == bc_ff));
                  state_ff  <= ST_OUT;
               end else if (miss) begin
                  flag_ff <= 1'b0;
               end else begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (test_status.done) begin
                  flag_ff  <= test_status.pass;
                  t_ff     <= NBR_W'(t_ff + 1'b1);
                  state_ff <= ST_TEST;
               end
            end
            ST_OUT: begin
               if (rsp_bus.ready) begin
                  rn_ff    <= IDX_W'(rn_ff + 1'b1);
                  cnt_ff   <= OUT_CNT_W'(cnt_ff + 1'b1);
                  state_ff <= ST_SCAN;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_bus.ready            = (state_ff == ST_IDLE);
   assign rsp_bus.valid            = (state_ff == ST_OUT);
   assign rsp_bus.bin_index        = o_idx_ff;
   assign rsp_bus.peak_flag        = o_flag_ff;
   assign rsp_bus.bin_rate_sum     = o_rate_ff;
   assign rsp_bus.bin_variance_sum = o_var_ff;
   assign rsp_bus.last_res         = o_last_ff;

`ifndef SYNTHESIS
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("sample and result beats open at once");

   a_bin_done: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rn_ff != bc_ff))
      else $error("result for a bin not yet complete");

   a_series_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && rsp_bus.last_res)
         |-> ##2 ((bc_ff == '0) && (rn_ff == '0)))
      else $error("series state kept after final result");
`endif
endmodule
